// ===== rtl/pyr_pkg.sv =====
// pyr_pkg: shared types, mode codes and constants for the packed yuv to rgb stream
// used by pyr_front, pyr_queue, pyr_back and packed_yuv_to_rgb_stream
`default_nettype none

package pyr_pkg;

    // default fraction bits of the conversion coefficients
    localparam int COEF_FRAC_BITS_DEF = 16;

    // coefficients in millionths
    localparam longint unsigned MICRO_KR  = 64'd1370705;
    localparam longint unsigned MICRO_KGV = 64'd698001;
    localparam longint unsigned MICRO_KGU = 64'd337633;
    localparam longint unsigned MICRO_KB  = 64'd1732446;

    // input_mode codes, code 3 behaves as mono8
    localparam logic [1:0] MODE_MONO8   = 2'd0;
    localparam logic [1:0] MODE_YUYV422 = 2'd1;
    localparam logic [1:0] MODE_YUYV411 = 2'd2;

    // register map
    localparam int         APB_ADDR_W     = 3;
    localparam int         APB_DATA_W     = 32;
    localparam logic [0:0] REG_INPUT_MODE = 1'b0;

    // group queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_in;

    // output word
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       group_last;
    } t_out;

    // one finished group: up to four luma values sharing one chroma pair
    typedef struct packed {
        logic            mono;
        logic [1:0]      last_idx;
        logic [3:0][7:0] y;
        logic [7:0]      u;
        logic [7:0]      v;
    } t_job;

endpackage

`default_nettype wire

// ===== rtl/pyr_front.sv =====
// pyr_front: accepts packed bytes, tracks the group position and holds group bytes
// builds one t_job per finished group; depends on pyr_pkg
`default_nettype none

module pyr_front
    import pyr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_mode,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire t_in        i_data,
    output logic            o_push,
    output t_job            o_job,
    input  wire logic       i_full
);

    logic [2:0]      r_pos;
    logic [2:0]      n_pos;
    logic [4:0][7:0] r_held;
    logic            accept;
    logic            is_mono;
    logic [2:0]      last_pos;
    logic [2:0]      pos_eff;
    logic            group_done;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    // group length from mode
    always_comb begin
        case (i_mode)
            MODE_YUYV422: begin
                is_mono  = 1'b0;
                last_pos = 3'd3;
            end
            MODE_YUYV411: begin
                is_mono  = 1'b0;
                last_pos = 3'd5;
            end
            default: begin
                is_mono  = 1'b1;
                last_pos = 3'd0;
            end
        endcase
    end

    // a stale position after a mode change restarts the group
    assign pos_eff    = (r_pos > last_pos) ? 3'd0 : r_pos;
    assign group_done = is_mono || (pos_eff == last_pos);

    // job assembly
    always_comb begin
        o_job      = '0;
        o_job.mono = is_mono;
        if (is_mono) begin
            o_job.last_idx = 2'd0;
            o_job.y[0]     = i_data.data_byte;
        end else if (i_mode == MODE_YUYV422) begin
            o_job.last_idx = 2'd1;
            o_job.y[0]     = r_held[0];
            o_job.y[1]     = r_held[2];
            o_job.u        = r_held[1];
            o_job.v        = i_data.data_byte;
        end else begin
            o_job.last_idx = 2'd3;
            o_job.y[0]     = r_held[1];
            o_job.y[1]     = r_held[2];
            o_job.y[2]     = r_held[4];
            o_job.y[3]     = i_data.data_byte;
            o_job.u        = r_held[0];
            o_job.v        = r_held[3];
        end
    end

    assign o_push = accept && group_done;

    // next group position
    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            if (group_done || i_data.frame_end) begin
                n_pos = 3'd0;
            end else begin
                n_pos = pos_eff + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 3'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // held bytes, written before read within a group
    always_ff @(posedge i_clk) begin
        if (accept && !group_done) begin
            for (int k = 0; k < 5; k++) begin
                if (pos_eff == 3'(k)) begin
                    r_held[k] <= i_data.data_byte;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pyr_queue.sv =====
// pyr_queue: short queue of finished groups between front and back
// depends on pyr_pkg for t_job and the queue depth
`default_nettype none

module pyr_queue
    import pyr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_head,
    output logic      o_empty
);

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr;
    logic [QUEUE_PTR_W-1:0] r_rd;
    logic [QUEUE_PTR_W:0]   r_count;

    assign o_full  = (r_count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("group pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("group popped from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

endmodule

`default_nettype wire

// ===== rtl/pyr_back.sv =====
// pyr_back: walks the pixels of each queued group through a three stage converter
// stage one multiplies, stage two sums and clamps, stage three scales converted pixels; uses pyr_pkg
`default_nettype none

module pyr_back
    import pyr_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_empty,
    input  wire t_job i_job,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_data
);

    localparam int F  = COEF_FRAC_BITS;
    localparam int SW = F + 11;

    localparam logic [F:0] KR  = (F+1)'(((MICRO_KR  << F) + 64'd500000) / 64'd1000000);
    localparam logic [F:0] KGV = (F+1)'(((MICRO_KGV << F) + 64'd500000) / 64'd1000000);
    localparam logic [F:0] KGU = (F+1)'(((MICRO_KGU << F) + 64'd500000) / 64'd1000000);
    localparam logic [F:0] KB  = (F+1)'(((MICRO_KB  << F) + 64'd500000) / 64'd1000000);

    // clamp a fixed point sum to 0..255, truncating the fraction
    function automatic logic [7:0] clamp_ch(input logic signed [SW-1:0] s);
        logic [7:0] c;
        if (s[SW-1]) begin
            c = 8'd0;
        end else if (s[F+9:F+8] != 2'b00) begin
            c = 8'd255;
        end else begin
            c = s[F+7:F];
        end
        return c;
    endfunction

    // floor(c * 220 / 256)
    function automatic logic [7:0] scale_ch(input logic [7:0] c);
        logic [15:0] p;
        p = 16'(c) * 16'd220;
        return p[15:8];
    endfunction

    logic        out_adv;
    logic        s2_adv;
    logic        s1_adv;
    logic        issue;
    logic [1:0]  r_idx;
    logic [7:0]  y_sel;
    logic signed [8:0] d;
    logic signed [8:0] e;

    logic              r_s1_valid;
    logic              r_s1_mono;
    logic              r_s1_last;
    logic [7:0]        r_s1_y;
    logic signed [SW-1:0] r_s1_pr;
    logic signed [SW-1:0] r_s1_pgv;
    logic signed [SW-1:0] r_s1_pgu;
    logic signed [SW-1:0] r_s1_pb;

    logic              r_s2_valid;
    logic              r_s2_mono;
    logic              r_s2_last;
    logic [7:0]        r_s2_r;
    logic [7:0]        r_s2_g;
    logic [7:0]        r_s2_b;

    logic              r_out_valid;
    t_out              r_out;

    logic signed [SW-1:0] ys;
    logic signed [SW-1:0] sum_r;
    logic signed [SW-1:0] sum_g;
    logic signed [SW-1:0] sum_b;

    // pipeline advance, one pixel per cycle when nothing stalls
    assign out_adv = !r_out_valid || !i_stall;
    assign s2_adv  = !r_s2_valid || out_adv;
    assign s1_adv  = !r_s1_valid || s2_adv;
    assign issue   = !i_empty && s1_adv;
    assign o_pop   = issue && (r_idx == i_job.last_idx);

    // pixel selection within the head group
    assign y_sel = i_job.y[r_idx];
    assign d     = $signed({1'b0, i_job.v}) - 9'sd128;
    assign e     = $signed({1'b0, i_job.u}) - 9'sd128;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (issue) begin
            r_idx <= o_pop ? 2'd0 : r_idx + 2'd1;
        end
    end

    // stage one: coefficient products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_mono <= i_job.mono;
            r_s1_last <= (r_idx == i_job.last_idx);
            r_s1_y    <= y_sel;
            r_s1_pr   <= SW'($signed({1'b0, KR}))  * SW'(d);
            r_s1_pgv  <= SW'($signed({1'b0, KGV})) * SW'(d);
            r_s1_pgu  <= SW'($signed({1'b0, KGU})) * SW'(e);
            r_s1_pb   <= SW'($signed({1'b0, KB}))  * SW'(e);
        end
    end

    // stage two: sums, truncation and clamp
    assign ys    = $signed({3'b000, r_s1_y, {F{1'b0}}});
    assign sum_r = ys + r_s1_pr;
    assign sum_g = ys - r_s1_pgv - r_s1_pgu;
    assign sum_b = ys + r_s1_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv && r_s1_valid) begin
            r_s2_mono <= r_s1_mono;
            r_s2_last <= r_s1_last;
            if (r_s1_mono) begin
                r_s2_r <= r_s1_y;
                r_s2_g <= r_s1_y;
                r_s2_b <= r_s1_y;
            end else begin
                r_s2_r <= clamp_ch(sum_r);
                r_s2_g <= clamp_ch(sum_g);
                r_s2_b <= clamp_ch(sum_b);
            end
        end
    end

    // stage three: output register with scaling for converted pixels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s2_valid) begin
            r_out.group_last <= r_s2_last;
            if (r_s2_mono) begin
                r_out.red   <= r_s2_r;
                r_out.green <= r_s2_g;
                r_out.blue  <= r_s2_b;
            end else begin
                r_out.red   <= scale_ch(r_s2_r);
                r_out.green <= scale_ch(r_s2_g);
                r_out.blue  <= scale_ch(r_s2_b);
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (r_idx <= i_job.last_idx))
        else $error("pixel index beyond head group");

    a_mono_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_mono) |-> r_s1_last)
        else $error("mono pixel without group_last");

    a_pop_issues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_s1_valid && r_s1_last)
        else $error("group popped without issuing its last pixel");

endmodule

`default_nettype wire

// ===== rtl/packed_yuv_to_rgb_stream.sv =====
// packed_yuv_to_rgb_stream: top level, holds the input_mode register on an apb-style port
// instantiates pyr_front, pyr_queue and pyr_back; depends on pyr_pkg
//
// Usage
//   Input channel i_valid / o_stall / i_data carries one packed frame byte per word
//   with a frame_end flag on the last byte of a frame. Output channel
//   o_valid / i_stall / o_data carries one rgb pixel per word, group_last set on
//   the last pixel of each group.
//   input_mode selects mono8, yuyv422 or yuyv411 (reset: yuyv422); write it only
//   while the block is idle.
//   One byte is accepted per cycle while the group queue has room. The back end
//   converts one pixel per cycle while the output does not stall, so mono8 runs
//   at one byte per cycle, yuyv422 at two pixels per four bytes and yuyv411 at
//   four pixels per six bytes. A group's pixels pass through the group queue and
//   the stage one, stage two and output registers once its last byte is accepted.
//   A stall on the output holds the three-stage converter; the four-entry group
//   queue then fills and o_stall rises, so no byte or pixel is lost.
//   Reset clears the group position, queue and pipeline valid flags.
`default_nettype none

module packed_yuv_to_rgb_stream
    import pyr_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire t_in                   i_data,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_out                       o_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [1:0] r_mode;
    logic       cfg_wr;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    t_job       push_job;
    t_job       head_job;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1:2] == REG_INPUT_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_YUYV422;
        end else if (cfg_wr) begin
            r_mode <= pwdata[1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_INPUT_MODE) begin
            prdata[1:0] = r_mode;
        end
    end

    // byte intake and grouping
    pyr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full)
    );

    // group queue
    pyr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_empty (empty)
    );

    // pixel conversion
    pyr_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire
